[hw/rtl/fbcb_pkg.sv]
// Shared types, constants and lookup functions for the floppy block command builder.
// Used by the front end, the job queue, the byte sequencer and the top level.
// No dependencies.
`timescale 1ns / 1ps

package fbcb_pkg;

  // Request geometry.
  localparam int unsigned BLOCK_BYTES      = 1024;
  localparam int unsigned SECTOR_BYTES     = 512;
  localparam int unsigned OFFSET_W         = 21;
  localparam int unsigned COUNT_W          = 16;
  localparam int unsigned SECTOR_SHIFT     = $clog2(SECTOR_BYTES);
  localparam int unsigned BLOCK_SHIFT      = $clog2(BLOCK_BYTES);
  localparam int unsigned SECT_W           = OFFSET_W - SECTOR_SHIFT;
  localparam int unsigned DISK_END_SECTORS = 2400;

  // Cylinder, remainder and sector widths for the largest track size.
  localparam int unsigned CYL_W  = 7;
  localparam int unsigned REM_W  = 5;
  localparam int unsigned SEC_W  = 4;
  localparam int unsigned DENS_W = 2;

  // Reciprocal division of the sector number by the cylinder size.
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP_W     = 12;
  localparam int unsigned PROD_W      = SECT_W + RECIP_W;

  // Controller command bytes.
  localparam logic [7:0] OPC_SEEK      = 8'h0F;
  localparam logic [7:0] OPC_READ      = 8'hE6;
  localparam logic [7:0] OPC_WRITE     = 8'hC5;
  localparam logic [7:0] DATA_LEN_BYTE = 8'hFF;

  // Default depth of the job queue between front end and sequencer.
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_DRIVE = 3'd1,
    ST_MISALIGN  = 3'd2,
    ST_DISK_END  = 3'd3,
    ST_BAD_COUNT = 3'd4,
    ST_CAPACITY  = 3'd5
  } status_e;

  // Position of a byte within the twelve-byte command run.
  typedef enum logic [3:0] {
    SLOT_SEEK_OPC  = 4'd0,
    SLOT_SEEK_UNIT = 4'd1,
    SLOT_SEEK_CYL  = 4'd2,
    SLOT_XFER_OPC  = 4'd3,
    SLOT_XFER_UNIT = 4'd4,
    SLOT_CYL       = 4'd5,
    SLOT_HEAD      = 4'd6,
    SLOT_SECTOR    = 4'd7,
    SLOT_SIZE      = 4'd8,
    SLOT_EOT       = 4'd9,
    SLOT_GAP       = 4'd10,
    SLOT_DTL       = 4'd11
  } slot_e;

  // Request after the checks, with the cylinder already divided out.
  typedef struct packed {
    status_e             status;
    logic                wr;
    logic                drv;
    logic [DENS_W-1:0]   dens;
    logic [SECT_W-1:0]   sect;
    logic [CYL_W-1:0]    cyl;
  } fbcb_stage_t;

  // Job handed to the byte sequencer.
  typedef struct packed {
    status_e             status;
    logic                wr;
    logic                drv;
    logic [DENS_W-1:0]   dens;
    logic                head;
    logic [CYL_W-1:0]    cyl;
    logic [SEC_W-1:0]    sec;
  } fbcb_job_t;

  // Sectors per track for each diskette and drive combination.
  function automatic logic [SEC_W-1:0] trk_sectors(input logic [DENS_W-1:0] dens);
    logic [SEC_W-1:0] r;
    unique case (dens)
      2'd3:    r = 4'd15;
      default: r = 4'd9;
    endcase
    return r;
  endfunction

  // Capacity in sectors.
  function automatic logic [SECT_W-1:0] capacity(input logic [DENS_W-1:0] dens);
    logic [SECT_W-1:0] r;
    unique case (dens)
      2'd3:    r = SECT_W'(2400);
      default: r = SECT_W'(720);
    endcase
    return r;
  endfunction

  // Seek step factor: double stepping for the low-density media in high-density drives.
  function automatic logic step_double(input logic [DENS_W-1:0] dens);
    logic r;
    unique case (dens)
      2'd1, 2'd2: r = 1'b1;
      default:    r = 1'b0;
    endcase
    return r;
  endfunction

  // Gap length.
  function automatic logic [7:0] gap_len(input logic [DENS_W-1:0] dens);
    logic [7:0] r;
    unique case (dens)
      2'd0, 2'd1: r = 8'h2A;
      2'd2:       r = 8'h23;
      default:    r = 8'h1B;
    endcase
    return r;
  endfunction

  // Rounded-up 2^16 / (2 * sectors per track): 3641 for 18, 2185 for 30.
  // Both are exact for every sector number below 2400.
  function automatic logic [RECIP_W-1:0] cyl_recip(input logic [DENS_W-1:0] dens);
    logic [RECIP_W-1:0] r;
    unique case (dens)
      2'd3:    r = RECIP_W'(2185);
      default: r = RECIP_W'(3641);
    endcase
    return r;
  endfunction

  // Size code for the sector length: 128 << code bytes.
  function automatic logic [7:0] size_code(input int unsigned bytes);
    logic [7:0] r;
    case (bytes)
      128:     r = 8'd0;
      256:     r = 8'd1;
      512:     r = 8'd2;
      1024:    r = 8'd3;
      2048:    r = 8'd4;
      default: r = 8'hFF;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/fbcb_front.sv]
// Front end of the floppy block command builder: checks a request, divides out
// the cylinder, and splits the remainder into head and sector for the job queue.
// Depends on fbcb_pkg.
`timescale 1ns / 1ps

module fbcb_front import fbcb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [OFFSET_W-1:0] byte_offset_i,
  input  logic [1:0]          drive_i,
  input  logic                write_request_i,
  input  logic [COUNT_W-1:0]  byte_count_i,
  input  logic [DENS_W-1:0]   density_drive0_i,
  input  logic [DENS_W-1:0]   density_drive1_i,
  output logic                stage_valid_o,
  output logic                push_o,
  output fbcb_job_t           job_o
);

  logic                  stage_valid_q;
  fbcb_stage_t           stage_q;
  fbcb_stage_t           stage_d;
  logic [SECT_W-1:0]     sect;
  logic [DENS_W-1:0]     dens;
  logic [PROD_W-1:0]     cyl_prod;
  logic [REM_W:0]        trk_size;
  logic [SECT_W-1:0]     cyl_base;
  logic [REM_W-1:0]      rem;
  logic [SEC_W-1:0]      spt;
  logic                  head;
  logic [REM_W-1:0]      sec_zero;

  // Checks in priority order, then the cylinder by reciprocal multiplication.
  always_comb begin
    sect = byte_offset_i[OFFSET_W-1:SECTOR_SHIFT];
    dens = drive_i[0] ? density_drive1_i : density_drive0_i;
    cyl_prod = PROD_W'(sect) * PROD_W'(cyl_recip(dens));

    stage_d.wr   = write_request_i;
    stage_d.drv  = drive_i[0];
    stage_d.dens = dens;
    stage_d.sect = sect;
    stage_d.cyl  = cyl_prod[RECIP_SHIFT +: CYL_W];

    if (drive_i > 2'd1) begin
      stage_d.status = ST_BAD_DRIVE;
    end else if (byte_offset_i[BLOCK_SHIFT-1:0] != '0) begin
      stage_d.status = ST_MISALIGN;
    end else if (sect >= SECT_W'(DISK_END_SECTORS)) begin
      stage_d.status = ST_DISK_END;
    end else if (byte_count_i != COUNT_W'(BLOCK_BYTES)) begin
      stage_d.status = ST_BAD_COUNT;
    end else if (sect >= capacity(dens)) begin
      stage_d.status = ST_CAPACITY;
    end else begin
      stage_d.status = ST_OK;
    end
  end

  // Check stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      stage_q <= stage_d;
    end
  end

  // Remainder within the cylinder gives head and 1-based sector.
  always_comb begin
    spt      = trk_sectors(stage_q.dens);
    trk_size = {1'b0, spt, 1'b0};
    cyl_base = SECT_W'(stage_q.cyl) * SECT_W'(trk_size);
    rem      = REM_W'(stage_q.sect - cyl_base);
    head     = (rem >= REM_W'(spt));
    sec_zero = head ? (rem - REM_W'(spt)) : rem;

    job_o.status = stage_q.status;
    job_o.wr     = stage_q.wr;
    job_o.drv    = stage_q.drv;
    job_o.dens   = stage_q.dens;
    job_o.head   = head;
    job_o.cyl    = stage_q.cyl;
    job_o.sec    = SEC_W'(sec_zero + REM_W'(1));
  end

  assign push_o        = stage_valid_q;
  assign stage_valid_o = stage_valid_q;

endmodule

[hw/rtl/fbcb_queue.sv]
// Short job queue between the front end and the byte sequencer.
// Depends on fbcb_pkg.
`timescale 1ns / 1ps

module fbcb_queue import fbcb_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  fbcb_job_t                  push_data_i,
  input  logic                       pop_i,
  output fbcb_job_t                  head_o,
  output logic                       not_empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fbcb_job_t          mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q;
  logic [PTR_W-1:0]   wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q;
  logic [PTR_W-1:0]   rd_ptr_d;
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   count_d;

  // Pointer wrap and occupancy.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o      = mem_q[rd_ptr_q];
  assign not_empty_o = (count_q != '0);
  assign count_o     = count_q;

  // A push into a full queue or a pop from an empty one would corrupt a job.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> count_q < CNT_W'(DEPTH))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("job queue underflow");

endmodule

[hw/rtl/fbcb_back.sv]
// Byte sequencer of the floppy block command builder: turns one job into the
// seek and transfer command bytes, or into a single error result.
// Depends on fbcb_pkg.
`timescale 1ns / 1ps

module fbcb_back import fbcb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_avail_i,
  input  fbcb_job_t  job_i,
  output logic       pop_o,
  output logic       result_valid_o,
  output logic [7:0] command_byte_o,
  output logic [2:0] status_o,
  output logic       last_o
);

  logic       active_q;
  logic       active_d;
  logic [3:0] slot_q;
  logic [3:0] slot_d;
  fbcb_job_t  job_q;
  logic       finishing;
  logic       is_err;
  logic [7:0] unit_byte;
  logic [7:0] cyl_byte;
  logic [7:0] byte_d;
  logic       res_valid_q;
  logic [7:0] res_byte_q;
  logic [2:0] res_status_q;
  logic       res_last_q;

  // Job sequencing: the next job is taken in the cycle the current one ends.
  always_comb begin
    is_err    = (job_q.status != ST_OK);
    finishing = active_q && (is_err || slot_q == SLOT_DTL);
    pop_o     = job_avail_i && (!active_q || finishing);
    active_d  = active_q;
    slot_d    = slot_q;
    if (pop_o) begin
      active_d = 1'b1;
      slot_d   = SLOT_SEEK_OPC;
    end else if (finishing) begin
      active_d = 1'b0;
    end else if (active_q) begin
      slot_d = slot_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      slot_q   <= SLOT_SEEK_OPC;
    end else begin
      active_q <= active_d;
      slot_q   <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
  end

  // Byte selection for the current slot.
  always_comb begin
    unit_byte = {5'd0, job_q.head, 1'b0, job_q.drv};
    cyl_byte  = {1'b0, job_q.cyl};
    if (is_err) begin
      byte_d = 8'd0;
    end else begin
      unique case (slot_e'(slot_q))
        SLOT_SEEK_OPC:  byte_d = OPC_SEEK;
        SLOT_SEEK_UNIT: byte_d = unit_byte;
        SLOT_SEEK_CYL:  byte_d = step_double(job_q.dens) ? {job_q.cyl, 1'b0} : cyl_byte;
        SLOT_XFER_OPC:  byte_d = job_q.wr ? OPC_WRITE : OPC_READ;
        SLOT_XFER_UNIT: byte_d = unit_byte;
        SLOT_CYL:       byte_d = cyl_byte;
        SLOT_HEAD:      byte_d = {7'd0, job_q.head};
        SLOT_SECTOR:    byte_d = {4'd0, job_q.sec};
        SLOT_SIZE:      byte_d = size_code(SECTOR_BYTES);
        SLOT_EOT:       byte_d = {4'd0, trk_sectors(job_q.dens)};
        SLOT_GAP:       byte_d = gap_len(job_q.dens);
        SLOT_DTL:       byte_d = DATA_LEN_BYTE;
        default:        byte_d = 8'd0;
      endcase
    end
  end

  // Result register: one byte per cycle, strobed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_byte_q   <= byte_d;
    res_status_q <= job_q.status;
    res_last_q   <= finishing;
  end

  assign result_valid_o = res_valid_q;
  assign command_byte_o = res_byte_q;
  assign status_o       = res_status_q;
  assign last_o         = res_last_q;

  // An error result is a single zero byte that closes its transaction.
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != ST_OK |-> last_o && command_byte_o == 8'd0)
    else $error("error result not a single closing zero byte");

  // The closing byte of a command run directly follows a non-closing byte.
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o && status_o == ST_OK |-> $past(result_valid_o)
      && !$past(last_o))
    else $error("command run broken before its last byte");

  // A job is only taken while the sequencer is free or ending its current job.
  a_pop_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !active_q || finishing)
    else $error("job taken while a run is in progress");

endmodule

[hw/rtl/floppy_block_command_builder_unit.sv]
// Top level of the floppy block command builder: configuration registers,
// front end, job queue and byte sequencer.
// Depends on fbcb_pkg, fbcb_front, fbcb_queue and fbcb_back.
//
//  Channel   Direction  Handshake                  Payload
//  request   in         start high, busy low       byte_offset_i, drive_i, write_request_i,
//                                                  byte_count_i
//  result    out        result_valid_o, 1 cycle    command_byte_o, status_o, last_o
//  config    in/out     APB write: psel & penable  pwdata (density per drive), prdata
//
// A valid request gives twelve result bytes on consecutive cycles; a rejected
// one gives one error result. The first result passes the check stage register,
// the job queue and the sequencer's job register before the result register
// strobes it. The byte sequencer emits one byte per cycle, so it sets the
// sustained request rate. Up to QUEUE_DEPTH_P requests are held; busy rises only
// when they are all taken. Reset clears control state and both density registers.
// Results cannot be stalled by the receiver.
`timescale 1ns / 1ps

module floppy_block_command_builder_unit import fbcb_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request transaction.
  input  logic                start,
  output logic                busy,
  input  logic [OFFSET_W-1:0] byte_offset_i,
  input  logic [1:0]          drive_i,
  input  logic                write_request_i,
  input  logic [COUNT_W-1:0]  byte_count_i,
  // Result transaction.
  output logic                result_valid_o,
  output logic [7:0]          command_byte_o,
  output logic [2:0]          status_o,
  output logic                last_o,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH_P + 1);

  logic [DENS_W-1:0] density_drive0_q;
  logic [DENS_W-1:0] density_drive1_q;
  logic              cfg_write;
  logic              take;
  logic              stage_valid;
  logic              push;
  fbcb_job_t         push_job;
  logic              pop;
  fbcb_job_t         head_job;
  logic              job_avail;
  logic [CNT_W-1:0]  q_count;
  logic [CNT_W:0]    in_flight;

  // Density registers, written over the configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      density_drive0_q <= '0;
      density_drive1_q <= '0;
    end else if (cfg_write) begin
      if (paddr[2]) begin
        density_drive1_q <= pwdata[DENS_W-1:0];
      end else begin
        density_drive0_q <= pwdata[DENS_W-1:0];
      end
    end
  end

  assign prdata = paddr[2] ? {30'd0, density_drive1_q} : {30'd0, density_drive0_q};

  // Accept while the check stage plus the queue leave room for one more job.
  assign in_flight = {1'b0, q_count} + {{CNT_W{1'b0}}, stage_valid};
  assign busy      = (in_flight >= (CNT_W + 1)'(QUEUE_DEPTH_P));
  assign take      = start && !busy;

  fbcb_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .take_i           (take),
    .byte_offset_i    (byte_offset_i),
    .drive_i          (drive_i),
    .write_request_i  (write_request_i),
    .byte_count_i     (byte_count_i),
    .density_drive0_i (density_drive0_q),
    .density_drive1_i (density_drive1_q),
    .stage_valid_o    (stage_valid),
    .push_o           (push),
    .job_o            (push_job)
  );

  fbcb_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .head_o      (head_job),
    .not_empty_o (job_avail),
    .count_o     (q_count)
  );

  fbcb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_avail_i    (job_avail),
    .job_i          (head_job),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .command_byte_o (command_byte_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

endmodule

[tb/floppy_block_command_builder_unit_tb.sv]
// Self-checking testbench for floppy_block_command_builder_unit: drives block requests
// and density register writes, predicts every command byte and checks it on arrival.
// Depends on fbcb_pkg and the floppy_block_command_builder_unit RTL.
`timescale 1ns / 1ps

module floppy_block_command_builder_unit_tb;
  import fbcb_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned RANDOM_PER_PHASE = 50;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned NUM_PHASES       = 5;
  localparam int unsigned MAX_PRINTED      = 30;
  localparam int unsigned LAST_BLOCK       = 1199;
  localparam int unsigned MAX_BLOCK        = 2047;

  // Register indexes; register i sits at byte address 4*i.
  localparam int unsigned REG_DENS_DRIVE0 = 0;
  localparam int unsigned REG_DENS_DRIVE1 = 1;

  // Size code of a 512-byte sector.
  localparam logic [7:0] SIZE_CODE_512 = 8'd2;

  // Byte count of one block at the count port's width.
  localparam logic [COUNT_W-1:0] BLK_COUNT = COUNT_W'(BLOCK_BYTES);

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [1:0]          drive;
    logic                wr;
    logic [COUNT_W-1:0]  count;
  } block_req_t;

  typedef struct packed {
    logic [7:0] cmd;
    status_e    st;
    logic       last;
  } cmd_byte_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [OFFSET_W-1:0] byte_offset_i;
  logic [1:0]          drive_i;
  logic                write_request_i;
  logic [COUNT_W-1:0]  byte_count_i;
  logic                result_valid_o;
  logic [7:0]          command_byte_o;
  logic [2:0]          status_o;
  logic                last_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  block_req_t  pending_reqs[$];
  cmd_byte_t   cmd_bytes_due[$];
  block_req_t  next_req;
  cmd_byte_t   due_byte;
  logic [1:0]  dens_drive0_q;
  logic [1:0]  dens_drive1_q;
  logic        req_fire = 1'b0;
  logic        idle_on;
  int unsigned gap_left = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;

  floppy_block_command_builder_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .byte_offset_i   (byte_offset_i),
    .drive_i         (drive_i),
    .write_request_i (write_request_i),
    .byte_count_i    (byte_count_i),
    .result_valid_o  (result_valid_o),
    .command_byte_o  (command_byte_o),
    .status_o        (status_o),
    .last_o          (last_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Prints one line per mismatch, up to a limit, and counts them all.
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  // Works out the command bytes (or the single error byte) of one accepted request
  // and appends them to the list of bytes still due.
  function automatic void predict_command_run(input block_req_t req);
    int unsigned sect;
    int unsigned spt;
    int unsigned cap;
    int unsigned step;
    int unsigned cyl;
    int unsigned head;
    int unsigned sec;
    logic [7:0]  gap;
    logic [7:0]  unit;
    logic [1:0]  dens;
    logic [7:0]  run[12];
    status_e     st;
    cmd_byte_t   b;
    sect = req.offset / SECTOR_BYTES;
    dens = (req.drive == 2'd0) ? dens_drive0_q : dens_drive1_q;
    // Geometry of each diskette and drive combination.
    case (dens)
      2'd3: begin
        spt = 15; cap = 2400; step = 1; gap = 8'h1B;
      end
      2'd2: begin
        spt = 9; cap = 720; step = 2; gap = 8'h23;
      end
      2'd1: begin
        spt = 9; cap = 720; step = 2; gap = 8'h2A;
      end
      default: begin
        spt = 9; cap = 720; step = 1; gap = 8'h2A;
      end
    endcase
    // The first failing check decides the status.
    if (req.drive > 2'd1) st = ST_BAD_DRIVE;
    else if ((req.offset % BLOCK_BYTES) != 0) st = ST_MISALIGN;
    else if (sect >= DISK_END_SECTORS) st = ST_DISK_END;
    else if (req.count != COUNT_W'(BLOCK_BYTES)) st = ST_BAD_COUNT;
    else if (sect >= cap) st = ST_CAPACITY;
    else st = ST_OK;
    if (st != ST_OK) begin
      b.cmd  = 8'h00;
      b.st   = st;
      b.last = 1'b1;
      cmd_bytes_due.push_back(b);
    end else begin
      cyl  = sect / (2 * spt);
      head = (sect % (2 * spt)) / spt;
      sec  = (sect % spt) + 1;
      unit = 8'((head << 2) | req.drive);
      run[0]  = OPC_SEEK;
      run[1]  = unit;
      run[2]  = 8'(cyl * step);
      run[3]  = req.wr ? OPC_WRITE : OPC_READ;
      run[4]  = unit;
      run[5]  = 8'(cyl);
      run[6]  = 8'(head);
      run[7]  = 8'(sec);
      run[8]  = SIZE_CODE_512;
      run[9]  = 8'(spt);
      run[10] = gap;
      run[11] = DATA_LEN_BYTE;
      for (int k = 0; k < 12; k++) begin
        b.cmd  = run[k];
        b.st   = ST_OK;
        b.last = (k == 11);
        cmd_bytes_due.push_back(b);
      end
    end
  endfunction

  function automatic block_req_t make_req(input logic [OFFSET_W-1:0] offset,
                                          input logic [1:0] drive, input logic wr,
                                          input logic [COUNT_W-1:0] count);
    block_req_t r;
    r.offset = offset;
    r.drive  = drive;
    r.wr     = wr;
    r.count  = count;
    return r;
  endfunction

  // Mostly well-formed requests with random content, the rest broken or pure noise.
  function automatic block_req_t make_random_req();
    block_req_t  r;
    int unsigned kind;
    int unsigned blk;
    kind = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) begin
      // Blocks at the edges of the small and large capacities.
      case ($urandom_range(0, 5))
        0: blk = 358;
        1: blk = 359;
        2: blk = 360;
        3: blk = 361;
        4: blk = LAST_BLOCK - 1;
        default: blk = LAST_BLOCK;
      endcase
    end else begin
      blk = $urandom_range(0, LAST_BLOCK);
    end
    r = make_req(OFFSET_W'(blk * BLOCK_BYTES), 2'($urandom_range(0, 1)), 1'($urandom),
                 BLK_COUNT);
    case (kind)
      7: begin
        if ($urandom_range(0, 1) == 0) r.drive = 2'($urandom_range(2, 3));
        else r.count = COUNT_W'($urandom);
      end
      8: begin
        if ($urandom_range(0, 1) == 0) begin
          r.offset = r.offset | OFFSET_W'($urandom_range(1, BLOCK_BYTES - 1));
        end else begin
          r.offset = OFFSET_W'($urandom_range(LAST_BLOCK + 1, MAX_BLOCK) * BLOCK_BYTES);
        end
      end
      9: r = make_req(OFFSET_W'($urandom), 2'($urandom), 1'($urandom), COUNT_W'($urandom));
      default: ;
    endcase
    return r;
  endfunction

  // Register write: setup cycle, then access cycle.
  task automatic write_density(input int unsigned idx, input logic [1:0] dens);
    logic [31:0] value;
    value = ($urandom & ~32'h3) | 32'(dens);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * idx);
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_DENS_DRIVE0) dens_drive0_q = dens;
    else if (idx == REG_DENS_DRIVE1) dens_drive1_q = dens;
  endtask

  // Register read: the data is taken at the edge that ends the access cycle.
  task automatic check_density(input int unsigned idx, input logic [1:0] dens);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 3'(4 * idx);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[DENS_W-1:0] !== dens) begin
      report_mismatch($sformatf("density register %0d reads %0d, expected %0d",
                                idx, prdata[DENS_W-1:0], dens));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Waits until every request is taken and every predicted byte has arrived.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || start || cmd_bytes_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Request driver: holds a transaction until it is taken, with random idle bursts.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || req_fire) begin
      if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        if (idle_on && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(0, 13);
          start <= 1'b0;
        end else begin
          next_req = pending_reqs.pop_front();
          byte_offset_i   <= next_req.offset;
          drive_i         <= next_req.drive;
          write_request_i <= next_req.wr;
          byte_count_i    <= next_req.count;
          start           <= 1'b1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predicts on each accepted request and checks each result byte.
  always @(posedge clk_i) begin
    req_fire = rst_ni && start && !busy;
    if (req_fire) begin
      predict_command_run(make_req(byte_offset_i, drive_i, write_request_i, byte_count_i));
    end
    if (rst_ni && result_valid_o) begin
      if (cmd_bytes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h status %0d",
                                  command_byte_o, status_o));
      end else begin
        due_byte = cmd_bytes_due.pop_front();
        if (command_byte_o !== due_byte.cmd) begin
          report_mismatch($sformatf("command_byte %02h, expected %02h",
                                    command_byte_o, due_byte.cmd));
        end
        if (status_o !== due_byte.st) begin
          report_mismatch($sformatf("status %0d, expected %0d", status_o, due_byte.st));
        end
        if (last_o !== due_byte.last) begin
          report_mismatch($sformatf("last %0b, expected %0b", last_o, due_byte.last));
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stimulus: directed requests at reset densities, then phases of random requests
  // under different density settings.
  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    byte_offset_i   = '0;
    drive_i         = '0;
    write_request_i = 1'b0;
    byte_count_i    = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    idle_on         = 1'b1;
    dens_drive0_q   = 2'd0;
    dens_drive1_q   = 2'd0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    check_density(REG_DENS_DRIVE0, 2'd0);
    check_density(REG_DENS_DRIVE1, 2'd0);

    // Valid runs at the first and last blocks of a small diskette and across a track.
    pending_reqs.push_back(make_req(21'd0, 2'd0, 1'b0, BLK_COUNT));
    pending_reqs.push_back(make_req(21'd0, 2'd1, 1'b1, BLK_COUNT));
    pending_reqs.push_back(make_req(21'd367616, 2'd0, 1'b1, BLK_COUNT));
    pending_reqs.push_back(make_req(21'd9216, 2'd0, 1'b0, BLK_COUNT));
    pending_reqs.push_back(make_req(21'd8192, 2'd1, 1'b1, BLK_COUNT));
    // Past the density capacity, and past the disk end.
    pending_reqs.push_back(make_req(21'd368640, 2'd1, 1'b0, BLK_COUNT));
    pending_reqs.push_back(make_req(21'd1227776, 2'd0, 1'b0, BLK_COUNT));
    pending_reqs.push_back(make_req(21'd1228800, 2'd0, 1'b0, BLK_COUNT));
    pending_reqs.push_back(make_req(21'h1FFC00, 2'd1, 1'b1, BLK_COUNT));
    // Misaligned offsets.
    pending_reqs.push_back(make_req(21'h1FFFFF, 2'd0, 1'b0, BLK_COUNT));
    pending_reqs.push_back(make_req(21'd512, 2'd0, 1'b0, BLK_COUNT));
    pending_reqs.push_back(make_req(21'd1, 2'd1, 1'b0, BLK_COUNT));
    // Bad drives; a bad drive wins over every other fault.
    pending_reqs.push_back(make_req(21'd0, 2'd2, 1'b0, BLK_COUNT));
    pending_reqs.push_back(make_req(21'h1FFFFF, 2'd3, 1'b1, 16'hFFFF));
    // Bad counts at the extremes and next to the block size.
    pending_reqs.push_back(make_req(21'd1024, 2'd0, 1'b0, 16'h0000));
    pending_reqs.push_back(make_req(21'd2048, 2'd1, 1'b1, 16'hFFFF));
    pending_reqs.push_back(make_req(21'd3072, 2'd0, 1'b0, BLK_COUNT - 16'd1));
    pending_reqs.push_back(make_req(21'd4096, 2'd1, 1'b0, BLK_COUNT + 16'd1));
    // Check order between faults.
    pending_reqs.push_back(make_req(21'd512, 2'd0, 1'b0, 16'h0000));
    pending_reqs.push_back(make_req(21'd1228800, 2'd1, 1'b1, 16'h0000));
    pending_reqs.push_back(make_req(21'd368640, 2'd0, 1'b0, 16'h0000));

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Density settings per phase; every value is used on both drives.
      case (p)
        1: begin
          write_density(REG_DENS_DRIVE0, 2'd3);
          write_density(REG_DENS_DRIVE1, 2'd1);
        end
        2: begin
          write_density(REG_DENS_DRIVE0, 2'd1);
          write_density(REG_DENS_DRIVE1, 2'd2);
        end
        3: begin
          write_density(REG_DENS_DRIVE0, 2'd2);
          write_density(REG_DENS_DRIVE1, 2'd3);
        end
        4: begin
          write_density(REG_DENS_DRIVE0, 2'd0);
          write_density(REG_DENS_DRIVE1, 2'd3);
        end
        default: ;
      endcase
      if (p != 0) begin
        check_density(REG_DENS_DRIVE0, dens_drive0_q);
        check_density(REG_DENS_DRIVE1, dens_drive1_q);
      end
      // The last phase runs without idle bursts.
      idle_on = (p != NUM_PHASES - 1);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        pending_reqs.push_back(make_random_req());
      end
      wait_drained();
    end

    if (mismatch_count == 0 && cmd_bytes_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
